/* rtl/tccs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants for the text console: operation and character
// codes, the classified command passed from front to back, queue depth.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int CHAR_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int TAB_STEP    = 4;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_SETCUR = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'd127;

    typedef enum logic [3:0] {
        KIND_NOP    = 4'd0,
        KIND_BS     = 4'd1,
        KIND_TAB    = 4'd2,
        KIND_NL     = 4'd3,
        KIND_DEL    = 4'd4,
        KIND_CHAR   = 4'd5,
        KIND_SETCUR = 4'd6,
        KIND_CLEAR  = 4'd7,
        KIND_READ   = 4'd8
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] code;
        logic [7:0]        col;
        logic [7:0]        row;
        logic              in_range;
    } t_cmd;

endpackage

/* rtl/text_console_cursor_scroll.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell text console with cursor, line wrap and scroll; a front end
// classifies beats into a two-entry queue, a back end executes them.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// input    in         i_valid / o_stall  i_op, i_char_code, i_col, i_row
// result   out        o_valid / i_stall  o_cell_value, o_cursor_col, o_cursor_row
//
// An item passes the back end through row, address and update states; a cell
// write adds a write state, a read of a touched row adds a wait and a data
// state, and a write to a row not touched since reset, clear or scroll first
// sweeps that row to zero one cell a cycle through the store's single write
// port. Scroll and clear act only on per-row valid bits. Reset clears the
// valid bits at once; no clearing pass follows it. A waiting result under
// i_stall holds the back end, and the queue takes two beats meanwhile.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_col,
    input  logic [7:0] i_row,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_cell_value,
    output logic [6:0] o_cursor_col,
    output logic [4:0] o_cursor_row
);
    import tccs_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_pop;

    tccs_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_col       (i_col),
        .i_row       (i_row),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    tccs_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_value (o_cell_value),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

endmodule

/* rtl/tccs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tccs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_front
// Input side: classify each beat into a command, clamp cursor targets,
// range-check reads, and hold commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module tccs_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_char_code,
    input  logic [7:0]           i_col,
    input  logic [7:0]           i_row,
    output logic                 o_cmd_valid,
    output tccs_pkg::t_cmd       o_cmd,
    input  logic                 i_cmd_pop
);
    import tccs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd            w_cmd;
    t_cmd            r_q [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;
    logic [PW:0]     n_count;
    logic            w_push;
    logic            w_pop;

    always_comb begin
        w_cmd          = '0;
        w_cmd.code     = i_char_code;
        w_cmd.col      = i_col;
        w_cmd.row      = i_row;
        w_cmd.in_range = (i_col < COLUMNS) && (i_row < ROWS);
        unique case (i_op)
            OP_PUT: begin
                unique case (i_char_code)
                    CH_NUL:        w_cmd.kind = KIND_NOP;
                    CH_BS:         w_cmd.kind = KIND_BS;
                    CH_TAB:        w_cmd.kind = KIND_TAB;
                    CH_LF, CH_CR:  w_cmd.kind = KIND_NL;
                    CH_DEL:        w_cmd.kind = KIND_DEL;
                    default:       w_cmd.kind = KIND_CHAR;
                endcase
            end
            OP_SETCUR: begin
                w_cmd.kind = KIND_SETCUR;
                if (i_col >= COLUMNS) begin
                    w_cmd.col = 8'(COLUMNS - 1);
                end
                if (i_row >= ROWS) begin
                    w_cmd.row = 8'(ROWS - 1);
                end
            end
            OP_CLEAR: w_cmd.kind = KIND_CLEAR;
            OP_READ:  w_cmd.kind = KIND_READ;
            default:  w_cmd.kind = KIND_NOP;
        endcase
    end

    assign o_stall     = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (!w_push && w_pop) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

/* rtl/tccs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_back
// Execution side: cursor, wrap and scroll, cell store with a rotating top
// row and per-row valid bits, row sweep on first write, and result register.
// ----------------------------------------------------------------------------
module tccs_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  tccs_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_cell_value,
    output logic [6:0]     o_cursor_col,
    output logic [4:0]     o_cursor_row
);
    import tccs_pkg::*;

    localparam int CW  = $clog2(COLUMNS);
    localparam int CW1 = CW + 1;
    localparam int RW  = $clog2(ROWS);
    localparam int RW1 = RW + 1;
    localparam int AW  = $clog2(COLUMNS * ROWS);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ROW    = 8'b0000_0010,
        S_ADDR   = 8'b0000_0100,
        S_SWEEP  = 8'b0000_1000,
        S_WRITE  = 8'b0001_0000,
        S_RDWAIT = 8'b0010_0000,
        S_RDDATA = 8'b0100_0000,
        S_UPD    = 8'b1000_0000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_line;
    logic [RW-1:0]     r_top;
    logic [RW-1:0]     r_cur_phys;
    logic [ROWS-1:0]   r_row_valid;
    logic [RW-1:0]     r_prow;
    logic [CW-1:0]     r_tcol;
    logic [AW-1:0]     r_base;
    logic [CW-1:0]     r_cnt;
    logic [CHAR_W-1:0] r_value;
    logic              r_out_valid;
    logic [7:0]        r_out_cell;
    logic [6:0]        r_out_col;
    logic [4:0]        r_out_row;

    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_line;
    logic [RW-1:0]     n_top;
    logic [RW-1:0]     n_phys;
    logic              w_adv;
    logic              w_clr_all;
    logic              w_drop_row;
    logic [CW:0]       w_c_inc;
    logic [CW:0]       w_c_tab;
    logic              w_write_needed;
    logic              w_out_free;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CHAR_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [CHAR_W-1:0] w_rdata;
    logic [RW-1:0]     w_target_row;

    function automatic logic [RW-1:0] wrap_row(input logic [RW:0] s);
        logic [RW:0] t;
        t = s;
        if (s >= RW1'(ROWS)) begin
            t = s - RW1'(ROWS);
        end
        return t[RW-1:0];
    endfunction

    assign w_out_free     = !r_out_valid || !i_stall;
    assign o_cmd_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign w_write_needed = (r_cmd.kind == KIND_CHAR) ||
                            ((r_cmd.kind == KIND_DEL) && (r_col != '0));
    assign w_target_row   = wrap_row({1'b0, r_top} + RW1'(RW'(r_cmd.row)));
    assign w_c_inc        = {1'b0, r_col} + CW1'(1);
    assign w_c_tab        = {1'b0, r_col} + CW1'(TAB_STEP);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_base + AW'(r_tcol);
        w_wdata = (r_cmd.kind == KIND_CHAR) ? r_cmd.code : '0;
        if (r_state == S_SWEEP) begin
            w_we    = 1'b1;
            w_waddr = r_base + AW'(r_cnt);
            w_wdata = '0;
        end else if (r_state == S_WRITE) begin
            w_we = 1'b1;
        end
    end

    assign w_raddr = r_base + AW'(r_tcol);

    tccs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (COLUMNS * ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_cmd_valid) n_state = S_ROW;
            S_ROW:    n_state = S_ADDR;
            S_ADDR: begin
                if (w_write_needed) begin
                    n_state = r_row_valid[r_prow] ? S_WRITE : S_SWEEP;
                end else if ((r_cmd.kind == KIND_READ) && r_cmd.in_range &&
                             r_row_valid[r_prow]) begin
                    n_state = S_RDWAIT;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_SWEEP:  if (r_cnt == CW'(COLUMNS - 1)) n_state = S_WRITE;
            S_WRITE:  n_state = S_UPD;
            S_RDWAIT: n_state = S_RDDATA;
            S_RDDATA: n_state = S_UPD;
            S_UPD:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_col      = r_col;
        n_line     = r_line;
        n_top      = r_top;
        n_phys     = r_cur_phys;
        w_adv      = 1'b0;
        w_clr_all  = 1'b0;
        w_drop_row = 1'b0;
        unique case (r_cmd.kind)
            KIND_BS, KIND_DEL: begin
                if (r_col != '0) begin
                    n_col = r_col - CW'(1);
                end
            end
            KIND_TAB: begin
                if (w_c_tab >= CW1'(COLUMNS)) begin
                    n_col = CW'(w_c_tab - CW1'(COLUMNS));
                    w_adv = 1'b1;
                end else begin
                    n_col = CW'(w_c_tab);
                end
            end
            KIND_NL: begin
                n_col = '0;
                w_adv = 1'b1;
            end
            KIND_CHAR: begin
                if (w_c_inc == CW1'(COLUMNS)) begin
                    n_col = '0;
                    w_adv = 1'b1;
                end else begin
                    n_col = CW'(w_c_inc);
                end
            end
            KIND_SETCUR: begin
                n_col  = CW'(r_cmd.col);
                n_line = RW'(r_cmd.row);
                n_phys = r_prow;
            end
            KIND_CLEAR: begin
                n_col     = '0;
                n_line    = '0;
                n_top     = '0;
                n_phys    = '0;
                w_clr_all = 1'b1;
            end
            default: begin
            end
        endcase
        if (w_adv) begin
            if (r_line == RW'(ROWS - 1)) begin
                n_top      = wrap_row({1'b0, r_top} + RW1'(1));
                n_phys     = r_top;
                w_drop_row = 1'b1;
            end else begin
                n_line = r_line + RW'(1);
                n_phys = wrap_row({1'b0, r_cur_phys} + RW1'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_line      <= '0;
            r_top       <= '0;
            r_cur_phys  <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_UPD) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_SWEEP) && (r_cnt == CW'(COLUMNS - 1))) begin
                r_row_valid[r_prow] <= 1'b1;
            end
            if ((r_state == S_UPD) && w_out_free) begin
                r_col       <= n_col;
                r_line      <= n_line;
                r_top       <= n_top;
                r_cur_phys  <= n_phys;
                if (w_clr_all) begin
                    r_row_valid <= '0;
                end else if (w_drop_row) begin
                    r_row_valid[r_top] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_ROW) begin
            r_value <= '0;
            r_cnt   <= '0;
            if ((r_cmd.kind == KIND_READ) || (r_cmd.kind == KIND_SETCUR)) begin
                r_prow <= w_target_row;
            end else begin
                r_prow <= r_cur_phys;
            end
            unique case (r_cmd.kind)
                KIND_READ:  r_tcol <= CW'(r_cmd.col);
                KIND_DEL:   r_tcol <= r_col - CW'(1);
                default:    r_tcol <= r_col;
            endcase
        end
        if (r_state == S_ADDR) begin
            r_base <= AW'(r_prow * COLUMNS);
        end
        if (r_state == S_SWEEP) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (r_state == S_RDDATA) begin
            r_value <= w_rdata;
        end
        if ((r_state == S_UPD) && w_out_free) begin
            r_out_cell <= r_value;
            r_out_col  <= 7'(n_col);
            r_out_row  <= 5'(n_line);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cell_value = r_out_cell;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;

endmodule

/* rtl/tccs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_checker
// Port-level checks on the console: reset, cursor bounds, result hold and
// queue-full behaviour.
// ----------------------------------------------------------------------------
module tccs_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_op,
    input logic [7:0] i_char_code,
    input logic [7:0] i_col,
    input logic [7:0] i_row,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_cell_value,
    input logic [6:0] o_cursor_col,
    input logic [4:0] o_cursor_row
);

    a_reset_drops_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_col < COLUMNS))
        else $error("cursor column beyond screen");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_row < ROWS))
        else $error("cursor row beyond screen");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_cell_value) &&
                                  $stable(o_cursor_col) && $stable(o_cursor_row)))
        else $error("stalled result changed");

    a_full_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && !o_stall))
        else $error("queue filled without an accepted beat");

endmodule

bind text_console_cursor_scroll tccs_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_op         (i_op),
    .i_char_code  (i_char_code),
    .i_col        (i_col),
    .i_row        (i_row),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_cell_value (o_cell_value),
    .o_cursor_col (o_cursor_col),
    .o_cursor_row (o_cursor_row)
);

/* verif/text_console_cursor_scroll_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_checker
// Watches both channels of the text console, keeps its own copy of the screen
// and cursor, predicts the result of every accepted input beat and compares
// each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_col,
    input  logic [7:0] i_row,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_cell_value,
    input  logic [6:0] i_cursor_col,
    input  logic [4:0] i_cursor_row,
    output int         o_errors,
    output int         o_pending
);
    import tccs_pkg::*;

    typedef struct {
        logic [7:0] cell_value;
        logic [6:0] col;
        logic [4:0] line;
    } t_console_result;

    logic [7:0]      screen [ROWS*COLUMNS];
    int unsigned     cur_col;
    int unsigned     cur_line;
    t_console_result results_due [$];
    int              error_count = 0;
    int              pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic void blank_screen();
        foreach (screen[i]) screen[i] = '0;
        cur_col  = 0;
        cur_line = 0;
    endfunction

    function automatic void scroll_up();
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
        for (int i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++)
            screen[i] = '0;
        cur_line--;
    endfunction

    function automatic void put_glyph(logic [7:0] code);
        if (code == CH_NUL)
            return;
        case (code)
            CH_BS: begin
                if (cur_col > 0)
                    cur_col--;
            end
            CH_TAB: cur_col += TAB_STEP;
            CH_LF, CH_CR: begin
                cur_line++;
                cur_col = 0;
            end
            CH_DEL: begin
                if (cur_col > 0) begin
                    cur_col--;
                    screen[cur_line * COLUMNS + cur_col] = '0;
                end
            end
            default: begin
                screen[cur_line * COLUMNS + cur_col] = code;
                cur_col++;
            end
        endcase
        while (cur_col >= COLUMNS) begin
            cur_col -= COLUMNS;
            cur_line++;
        end
        while (cur_line >= ROWS)
            scroll_up();
    endfunction

    function automatic t_console_result apply_beat(t_op op, logic [7:0] code,
                                                   logic [7:0] col, logic [7:0] row);
        t_console_result res;
        res.cell_value = '0;
        case (op)
            OP_PUT:    put_glyph(code);
            OP_SETCUR: begin
                cur_col  = (col >= COLUMNS) ? COLUMNS - 1 : col;
                cur_line = (row >= ROWS) ? ROWS - 1 : row;
            end
            OP_CLEAR:  blank_screen();
            OP_READ: begin
                if (col < COLUMNS && row < ROWS)
                    res.cell_value = screen[row * COLUMNS + col];
            end
        endcase
        res.col  = cur_col[6:0];
        res.line = cur_line[4:0];
        return res;
    endfunction

    initial begin
        blank_screen();
    end

    always @(posedge i_clk) begin
        t_console_result want;
        if (!i_rst_n) begin
            blank_screen();
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    if (i_cell_value !== want.cell_value) begin
                        $error("cell_value: expected %0d, got %0d",
                               want.cell_value, i_cell_value);
                        error_count++;
                    end
                    if (i_cursor_col !== want.col) begin
                        $error("cursor_col: expected %0d, got %0d",
                               want.col, i_cursor_col);
                        error_count++;
                    end
                    if (i_cursor_row !== want.line) begin
                        $error("cursor_row: expected %0d, got %0d",
                               want.line, i_cursor_row);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(apply_beat(t_op'(i_op), i_char_code, i_col, i_row));
        end
        pending_count = results_due.size();
    end

endmodule

/* verif/text_console_cursor_scroll_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// Drives the text console with a directed run over the control codes, wrap,
// scroll, clamping and out-of-range reads, then random traffic in three
// throttling phases with one long result hold-off; the checker does the rest.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_tb;
    import tccs_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int RANDOM_RUN  = 375;
    localparam int CYCLE_LIMIT = 1000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_op;
    logic [7:0] i_char_code;
    logic [7:0] i_col;
    logic [7:0] i_row;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_cell_value;
    logic [6:0] o_cursor_col;
    logic [4:0] o_cursor_row;

    int          check_errors;
    int          results_pending;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left;
    int unsigned cycle_count;
    logic [7:0]  near_row;

    text_console_cursor_scroll #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_col        (i_col),
        .i_row        (i_row),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_value (o_cell_value),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

    text_console_cursor_scroll_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_cell_value (o_cell_value),
        .i_cursor_col (o_cursor_col),
        .i_cursor_row (o_cursor_row),
        .o_errors     (check_errors),
        .o_pending    (results_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_console_cursor_scroll_tb: FAIL");
            $finish;
        end
    end

    // hold off for a long stretch when asked, otherwise stall at random
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_beat(input t_op op, input logic [7:0] code,
                             input logic [7:0] col, input logic [7:0] row);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_char_code <= code;
        i_col       <= col;
        i_row       <= row;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random();
        int unsigned pick;
        logic [7:0]  code;
        logic [7:0]  col;
        logic [7:0]  row;
        pick = $urandom_range(199);
        code = 8'($urandom);
        col  = 8'($urandom);
        row  = 8'($urandom);
        if (pick < 110) begin
            case ($urandom_range(11))
                0:       code = CH_LF;
                1:       code = CH_CR;
                2:       code = CH_BS;
                3:       code = CH_DEL;
                4:       code = CH_TAB;
                5:       code = CH_NUL;
                6, 7:    code = 8'($urandom_range(255));
                default: code = 8'($urandom_range(126, 32));
            endcase
            send_beat(OP_PUT, code, col, row);
        end else if (pick < 140) begin
            if ($urandom_range(3) != 0) begin
                col = 8'($urandom_range(COLUMNS - 1));
                row = 8'($urandom_range(ROWS - 1));
            end
            // favour the bottom line so that scrolling comes often
            if ($urandom_range(2) == 0)
                row = 8'(ROWS - 1);
            near_row = (row >= ROWS) ? 8'(ROWS - 1) : row;
            send_beat(OP_SETCUR, code, col, row);
        end else if (pick < 199) begin
            if ($urandom_range(4) != 0) begin
                col = 8'($urandom_range(COLUMNS - 1));
                row = (near_row > 1) ? 8'(near_row - $urandom_range(2)) : near_row;
            end
            send_beat(OP_READ, code, col, row);
        end else begin
            send_beat(OP_CLEAR, code, col, row);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_op          = OP_PUT;
        i_char_code   = '0;
        i_col         = '0;
        i_row         = '0;
        hold_left     = 0;
        cycle_count   = 0;
        near_row      = '0;
        send_idle_pct = 37;
        recv_idle_pct = 72;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(OP_READ,   8'd0,   8'd0,   8'd0);
        send_beat(OP_READ,   8'd0,   8'd255, 8'd255);
        send_beat(OP_PUT,    8'd65,  8'd0,   8'd0);
        send_beat(OP_PUT,    CH_NUL, 8'd255, 8'd255);
        send_beat(OP_PUT,    8'd255, 8'd0,   8'd0);
        send_beat(OP_PUT,    8'd128, 8'd0,   8'd0);
        send_beat(OP_PUT,    8'd1,   8'd0,   8'd0);
        send_beat(OP_PUT,    CH_BS,  8'd0,   8'd0);
        send_beat(OP_PUT,    CH_DEL, 8'd0,   8'd0);
        send_beat(OP_READ,   8'd0,   8'd0,   8'd0);
        send_beat(OP_PUT,    CH_TAB, 8'd0,   8'd0);
        send_beat(OP_SETCUR, 8'd0,   8'd255, 8'd255);
        send_beat(OP_PUT,    8'd90,  8'd0,   8'd0);
        send_beat(OP_READ,   8'd0,   8'd79,  8'd23);
        send_beat(OP_SETCUR, 8'd0,   8'd78,  8'd24);
        send_beat(OP_PUT,    CH_TAB, 8'd0,   8'd0);
        send_beat(OP_PUT,    CH_LF,  8'd0,   8'd0);
        send_beat(OP_PUT,    CH_CR,  8'd0,   8'd0);
        send_beat(OP_SETCUR, 8'd0,   8'd0,   8'd5);
        send_beat(OP_PUT,    CH_BS,  8'd0,   8'd0);
        send_beat(OP_PUT,    CH_DEL, 8'd0,   8'd0);
        send_beat(OP_READ,   8'd0,   8'd80,  8'd0);
        send_beat(OP_READ,   8'd0,   8'd0,   8'd25);
        send_beat(OP_CLEAR,  8'd0,   8'd0,   8'd0);
        send_beat(OP_READ,   8'd0,   8'd0,   8'd23);

        repeat (RANDOM_RUN) send_random();

        send_idle_pct = 72;
        recv_idle_pct = 37;
        repeat (RANDOM_RUN) send_random();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_RUN; i++) begin
            if (i == 100)
                hold_left = 400;
            send_random();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);

        if (check_errors == 0)
            $display("text_console_cursor_scroll_tb: PASS");
        else
            $display("text_console_cursor_scroll_tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tccs_pkg.sv
rtl/tccs_ram.sv
rtl/tccs_front.sv
rtl/tccs_back.sv
rtl/text_console_cursor_scroll.sv
rtl/tccs_checker.sv
verif/text_console_cursor_scroll_checker.sv
verif/text_console_cursor_scroll_tb.sv
